FILE: rtl/core/longest_valid_paren_run_macros.svh
// Assertion macros for the longest valid bracket run block.
// Used by files that assert; expects clk and rst in scope.
`ifndef LONGEST_VALID_PAREN_RUN_MACROS_SVH
`define LONGEST_VALID_PAREN_RUN_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define LVPR_CHECK(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define LVPR_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/lvpr_pkg.sv
// Shared types and constants for the longest valid bracket run block.
// No dependencies; the other files that use it refer to it by scoped names.
package lvpr_pkg;

  localparam int MAX_LEN = 1024;
  localparam int STACK_N = MAX_LEN + 1;
  localparam int POS_W   = $clog2(MAX_LEN + 1);
  localparam int DEPTH_W = $clog2(STACK_N + 1);

  typedef logic [POS_W-1:0]   pos_t;
  typedef logic [DEPTH_W-1:0] depth_t;

  localparam pos_t   MAX_POS    = pos_t'(MAX_LEN);
  localparam depth_t DEPTH_FULL = depth_t'(STACK_N);
  localparam depth_t DEPTH_BASE = depth_t'(1);

  localparam logic [7:0] OPENER = 8'd40;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_PUSH,
    OP_POP,
    OP_LOAD
  } cell_op_t;

  typedef struct packed {
    pos_t longest;
    logic overflow;
  } result_t;

endpackage

FILE: rtl/core/lvpr_in_if.sv
// Request channel carrying one character byte and its end-of-string mark.
// Depends on nothing.
interface lvpr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       last;

  modport source (output valid, output symbol, output last, input ready);
  modport sink   (input valid, input symbol, input last, output ready);
endinterface

FILE: rtl/core/lvpr_out_if.sv
// Result channel carrying the longest run length and the overflow flag.
// Depends on lvpr_pkg for the length width.
interface lvpr_out_if;
  logic              valid;
  logic              ready;
  lvpr_pkg::pos_t    longest;
  logic              overflow;

  modport source (output valid, output longest, output overflow, input ready);
  modport sink   (input valid, input longest, input overflow, output ready);
endinterface

FILE: rtl/core/lvpr_cell.sv
// One slot of the shifting position stack.
// Depends on lvpr_pkg for the position type and the cell operation codes.
module lvpr_cell (
  input  logic               clk,
  input  logic               rst,
  input  lvpr_pkg::cell_op_t op,
  input  lvpr_pkg::pos_t     up,
  input  lvpr_pkg::pos_t     down,
  output lvpr_pkg::pos_t     pos
);

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else begin
      unique case (op) inside
        lvpr_pkg::OP_PUSH, lvpr_pkg::OP_LOAD: begin
          pos <= up;
        end
        lvpr_pkg::OP_POP: begin
          pos <= down;
        end
        default: begin
          pos <= pos;
        end
      endcase
    end
  end

endmodule

FILE: rtl/core/lvpr_out_buf.sv
// Two-deep result buffer: output register plus skid slot.
// Depends on lvpr_pkg and lvpr_out_if.
module lvpr_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  lvpr_pkg::result_t data,
  output logic              room,
  lvpr_out_if.source        results
);

  logic              head_valid;
  lvpr_pkg::result_t head;
  logic              skid_valid;
  lvpr_pkg::result_t skid;
  logic              take;

  assign take = head_valid & results.ready;
  assign room = ~skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (take || !head_valid) begin
      // advance: skid first, else the fresh result
      if (skid_valid) begin
        head       <= skid;
        skid_valid <= 1'b0;
      end else begin
        head_valid <= push;
        head       <= data;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
      skid       <= data;
    end
  end

  assign results.valid    = head_valid;
  assign results.longest  = head.longest;
  assign results.overflow = head.overflow;

endmodule

FILE: rtl/core/longest_valid_paren_run.sv
// Longest valid bracket run: takes one character per cycle, with no gap between
// strings, and on the character marked last delivers the length of the longest
// well-formed bracket substring and an overflow flag. '(' opens, any other byte
// closes. Open positions sit in a row of MAX_LEN+1 stack cells that shift down on
// a push and up on a pop, so the top and the entry under it are always at hand.
// Results pass through a two-deep output buffer; input stalls only when both
// of its slots are full. Characters after the first MAX_LEN are ignored and
// raise overflow. State clears itself after each last character; no clearing
// pass after reset.
`include "longest_valid_paren_run_macros.svh"

module longest_valid_paren_run (
  input  logic       clk,
  input  logic       rst,
  lvpr_in_if.sink    symbols,
  lvpr_out_if.source results
);

  lvpr_pkg::pos_t     char_pos, char_pos_next;
  lvpr_pkg::depth_t   depth, depth_next;
  lvpr_pkg::pos_t     best, best_next;
  logic               exceeded, exceeded_next;

  lvpr_pkg::pos_t     cell_pos [lvpr_pkg::STACK_N];
  lvpr_pkg::cell_op_t op_top;
  lvpr_pkg::cell_op_t op_rest;
  lvpr_pkg::pos_t     top_up;

  logic               room;
  logic               accept;
  logic               ignore;
  logic               opener;
  logic               do_push;
  logic               do_pop;
  logic               do_base;
  lvpr_pkg::pos_t     here;
  lvpr_pkg::pos_t     run;
  lvpr_pkg::pos_t     best_eff;
  logic               exceeded_eff;
  lvpr_pkg::result_t  result;

  assign symbols.ready = room;
  assign accept = symbols.valid & room;
  assign ignore = (char_pos == lvpr_pkg::MAX_POS);
  assign opener = (symbols.symbol == lvpr_pkg::OPENER);
  assign here   = char_pos + lvpr_pkg::pos_t'(1);
  assign run    = here - cell_pos[1];

  assign do_push = accept & ~ignore & opener & (depth != lvpr_pkg::DEPTH_FULL);
  assign do_pop  = accept & ~ignore & ~opener & (depth != lvpr_pkg::DEPTH_BASE);
  assign do_base = accept & ~ignore & ~opener & (depth == lvpr_pkg::DEPTH_BASE);

  assign best_eff     = (do_pop && (run > best)) ? run : best;
  assign exceeded_eff = exceeded | (accept & ignore);

  always_comb begin
    char_pos_next = char_pos;
    depth_next    = depth;
    best_next     = best_eff;
    exceeded_next = exceeded_eff;
    if (accept && !ignore) begin
      char_pos_next = here;
    end
    if (do_push) begin
      depth_next = depth + lvpr_pkg::depth_t'(1);
    end else if (do_pop) begin
      depth_next = depth - lvpr_pkg::depth_t'(1);
    end
    // drop everything back to the reset picture after the final character
    if (accept && symbols.last) begin
      char_pos_next = '0;
      depth_next    = lvpr_pkg::DEPTH_BASE;
      best_next     = '0;
      exceeded_next = 1'b0;
    end
  end

  always_comb begin
    op_top  = lvpr_pkg::OP_HOLD;
    op_rest = lvpr_pkg::OP_HOLD;
    top_up  = here;
    if (accept && symbols.last) begin
      op_top = lvpr_pkg::OP_LOAD;
      top_up = '0;
    end else if (do_push) begin
      op_top  = lvpr_pkg::OP_PUSH;
      op_rest = lvpr_pkg::OP_PUSH;
    end else if (do_pop) begin
      op_top  = lvpr_pkg::OP_POP;
      op_rest = lvpr_pkg::OP_POP;
    end else if (do_base) begin
      op_top = lvpr_pkg::OP_LOAD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_pos <= '0;
      depth    <= lvpr_pkg::DEPTH_BASE;
      best     <= '0;
      exceeded <= 1'b0;
    end else begin
      char_pos <= char_pos_next;
      depth    <= depth_next;
      best     <= best_next;
      exceeded <= exceeded_next;
    end
  end

  for (genvar i = 0; i < lvpr_pkg::STACK_N; i++) begin : g_cell
    if (i == 0) begin : g_top
      lvpr_cell u_cell (
        .clk  (clk),
        .rst  (rst),
        .op   (op_top),
        .up   (top_up),
        .down (cell_pos[1]),
        .pos  (cell_pos[0])
      );
    end else if (i == lvpr_pkg::STACK_N - 1) begin : g_bottom
      lvpr_cell u_cell (
        .clk  (clk),
        .rst  (rst),
        .op   (op_rest),
        .up   (cell_pos[i-1]),
        .down ('0),
        .pos  (cell_pos[i])
      );
    end else begin : g_mid
      lvpr_cell u_cell (
        .clk  (clk),
        .rst  (rst),
        .op   (op_rest),
        .up   (cell_pos[i-1]),
        .down (cell_pos[i+1]),
        .pos  (cell_pos[i])
      );
    end
  end

  assign result.longest  = best_eff;
  assign result.overflow = exceeded_eff;

  lvpr_out_buf u_out_buf (
    .clk     (clk),
    .rst     (rst),
    .push    (accept & symbols.last),
    .data    (result),
    .room    (room),
    .results (results)
  );

  `LVPR_CHECK(a_depth_range, 1'b1, (depth >= lvpr_pkg::DEPTH_BASE) && (depth <= lvpr_pkg::DEPTH_FULL), "stack depth out of range")
  `LVPR_CHECK(a_depth_vs_pos, 1'b1, ({1'b0, depth} <= {1'b0, char_pos} + 12'd1), "stack deeper than characters taken")
  `LVPR_CHECK(a_best_vs_pos, 1'b1, best <= char_pos, "best run longer than characters taken")
  `LVPR_CHECK(a_pos_limit, 1'b1, char_pos <= lvpr_pkg::MAX_POS, "character count past limit")
  `LVPR_CHECK_NEXT(a_clear_after_last, accept && symbols.last, (char_pos == '0) && (depth == lvpr_pkg::DEPTH_BASE) && (best == '0) && !exceeded && (cell_pos[0] == '0), "state not cleared after last character")

endmodule
